// File: rtl/core/acfd_pkg.sv
// shared constants and types of the link frame deframer
package acfd_pkg;

  // fixed frame bytes
  localparam logic [7:0] HDR_B0      = 8'hd0;
  localparam logic [7:0] HDR_B1      = 8'hc0;
  localparam logic [7:0] HDR_B2      = 8'h02;
  localparam logic [7:0] SEP_BYTE    = 8'hfe;
  localparam logic [7:0] FOOTER_BYTE = 8'he0;

  // byte positions within the frame header
  localparam logic [8:0] POS_HDR0     = 9'd0;
  localparam logic [8:0] POS_HDR1     = 9'd1;
  localparam logic [8:0] POS_HDR2     = 9'd2;
  localparam logic [8:0] POS_LEN      = 9'd3;
  localparam logic [8:0] POS_ZERO_LO  = 9'd4;
  localparam logic [8:0] POS_ZERO_HI  = 9'd8;
  localparam logic [8:0] POS_CNT      = 9'd9;
  localparam logic [8:0] POS_SEP      = 9'd10;
  localparam logic [8:0] POS_TYPE_HI  = 9'd11;
  localparam logic [8:0] POS_TYPE_LO  = 9'd12;
  localparam logic [8:0] POS_PLEN     = 9'd13;
  localparam logic [8:0] PAYLOAD_START = 9'd14;
  localparam logic [9:0] FRAME_OVERHEAD = 10'd16;
  localparam logic [8:0] BYTE_CNT_MAX  = 9'd511;

  // record walker phases
  localparam logic [1:0] PH_ID   = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  // sticky error flag bits
  localparam int FL_CSUM = 0;
  localparam int FL_HDR  = 1;
  localparam int FL_ZERO = 2;
  localparam int FL_SEP  = 3;
  localparam int FL_OVR  = 4;
  localparam int FL_W    = 5;

  // frame status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_CSUM   = 3'd2;
  localparam logic [2:0] ST_HEADER = 3'd3;
  localparam logic [2:0] ST_ZERO   = 3'd4;
  localparam logic [2:0] ST_SEP    = 3'd5;
  localparam logic [2:0] ST_FOOTER = 3'd6;
  localparam logic [2:0] ST_OVERRUN = 3'd7;

  localparam logic KIND_REG    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  reg_id;
    logic [7:0]  reg_len;
    logic [7:0]  byte_pos;
    logic [7:0]  value_byte;
    logic        has_value;
    logic        reg_done;
    logic [2:0]  frame_status;
    logic [7:0]  msg_counter;
    logic [15:0] message_type;
    logic [7:0]  message_len;
    logic [7:0]  payload_len;
  } acfd_result_t;

endpackage

// File: rtl/core/acfd_in_if.sv
// input channel: one received frame byte per transfer
interface acfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: rtl/core/acfd_out_if.sv
// result channel: register value results and end-of-frame status
interface acfd_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  reg_id;
  logic [7:0]  reg_len;
  logic [7:0]  byte_pos;
  logic [7:0]  value_byte;
  logic        has_value;
  logic        reg_done;
  logic [2:0]  frame_status;
  logic [7:0]  msg_counter;
  logic [15:0] message_type;
  logic [7:0]  message_len;
  logic [7:0]  payload_len;

  modport source (
    output valid, output out_kind, output reg_id, output reg_len, output byte_pos,
    output value_byte, output has_value, output reg_done, output frame_status,
    output msg_counter, output message_type, output message_len, output payload_len,
    input ready
  );
  modport sink (
    input valid, input out_kind, input reg_id, input reg_len, input byte_pos,
    input value_byte, input has_value, input reg_done, input frame_status,
    input msg_counter, input message_type, input message_len, input payload_len,
    output ready
  );
endinterface

// File: rtl/core/ac_link_frame_deframer_core.sv
// link frame deframer: header checks, record walk and frame status
// each byte's result is registered in the result register, or in the skid entry while an earlier result waits
// throughput: one byte per cycle while the skid entry is empty; frame state updates in a single pass per byte
// a two-entry output buffer (result register plus skid) keeps input ready while a result waits
// reset: rst_n synchronous, active low; clears frame state and empties the output buffer
// frame state also clears itself after every byte marked as frame end
module ac_link_frame_deframer_core
  import acfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  acfd_in_if.sink        in_ch,
  acfd_out_if.source     out_ch
);

  logic [8:0]     byte_cnt_r,  byte_cnt_nxt;
  logic [7:0]     xor_r,       xor_nxt;
  logic [FL_W-1:0] flags_r,    flags_nxt;
  logic [7:0]     msg_len_r,   msg_len_nxt;
  logic [7:0]     counter_r,   counter_nxt;
  logic [15:0]    mtype_r,     mtype_nxt;
  logic [7:0]     pld_len_r,   pld_len_nxt;
  logic [1:0]     phase_r,     phase_nxt;
  logic [7:0]     cur_id_r,    cur_id_nxt;
  logic [7:0]     cur_len_r,   cur_len_nxt;
  logic [7:0]     vidx_r,      vidx_nxt;

  acfd_result_t   out_data_r, skid_data_r, res;
  logic           out_valid_r, skid_valid_r;

  logic           acc;
  logic           emit;
  logic [7:0]     b;
  logic [8:0]     pos;
  logic [8:0]     pay_end;
  logic [9:0]     n_bytes;
  logic [2:0]     status;

  assign acc     = in_ch.valid && in_ch.ready;
  assign b       = in_ch.rx_byte;
  assign pos     = byte_cnt_r;
  assign pay_end = PAYLOAD_START + {1'b0, pld_len_r};
  assign n_bytes = {1'b0, pos} + 10'd1;

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    xor_nxt      = xor_r;
    flags_nxt    = flags_r;
    msg_len_nxt  = msg_len_r;
    counter_nxt  = counter_r;
    mtype_nxt    = mtype_r;
    pld_len_nxt  = pld_len_r;
    phase_nxt    = phase_r;
    cur_id_nxt   = cur_id_r;
    cur_len_nxt  = cur_len_r;
    vidx_nxt     = vidx_r;
    emit         = 1'b0;
    status       = ST_OK;
    res          = '0;

    if (pos < PAYLOAD_START) begin
      xor_nxt = xor_r ^ b;
      if ((pos == POS_HDR0 && b != HDR_B0) || (pos == POS_HDR1 && b != HDR_B1) ||
          (pos == POS_HDR2 && b != HDR_B2)) begin
        flags_nxt[FL_HDR] = 1'b1;
      end
      if (pos inside {[POS_ZERO_LO:POS_ZERO_HI]} && b != 8'd0) begin
        flags_nxt[FL_ZERO] = 1'b1;
      end
      if (pos == POS_SEP && b != SEP_BYTE) begin
        flags_nxt[FL_SEP] = 1'b1;
      end
      if (pos == POS_LEN)     msg_len_nxt = b;
      if (pos == POS_CNT)     counter_nxt = b;
      if (pos == POS_TYPE_HI) mtype_nxt[15:8] = b;
      if (pos == POS_TYPE_LO) mtype_nxt[7:0] = b;
      if (pos == POS_PLEN)    pld_len_nxt = b;
    end else if (pos < pay_end) begin
      xor_nxt = xor_r ^ b;
      case (phase_r)
        PH_ID: begin
          cur_id_nxt = b;
          // id on the last payload byte leaves no room for its length
          if (n_bytes >= {1'b0, pay_end}) begin
            flags_nxt[FL_OVR] = 1'b1;
            phase_nxt = PH_STOP;
          end else begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          cur_len_nxt = b;
          if ({1'b0, pos} + {2'b00, b} >= {1'b0, pay_end}) begin
            flags_nxt[FL_OVR] = 1'b1;
            phase_nxt = PH_STOP;
          end else if (b == 8'd0) begin
            emit          = 1'b1;
            res.reg_done  = 1'b1;
            phase_nxt     = PH_ID;
          end else begin
            vidx_nxt  = 8'd0;
            phase_nxt = PH_VAL;
          end
        end
        PH_VAL: begin
          emit           = 1'b1;
          res.byte_pos   = vidx_r;
          res.value_byte = b;
          res.has_value  = 1'b1;
          if ({1'b0, vidx_r} + 9'd1 >= {1'b0, cur_len_r}) begin
            res.reg_done = 1'b1;
            phase_nxt    = PH_ID;
          end else begin
            vidx_nxt = vidx_r + 8'd1;
          end
        end
        default: ;
      endcase
    end else if (pos == pay_end) begin
      if (b != xor_r) flags_nxt[FL_CSUM] = 1'b1;
    end

    if (byte_cnt_r != BYTE_CNT_MAX) byte_cnt_nxt = byte_cnt_r + 9'd1;

    res.out_kind     = KIND_REG;
    res.reg_id       = cur_id_nxt;
    res.reg_len      = cur_len_nxt;
    res.frame_status = ST_OK;
    res.msg_counter  = counter_nxt;
    res.message_type = mtype_nxt;
    res.message_len  = msg_len_nxt;
    res.payload_len  = pld_len_nxt;

    if (in_ch.frame_end) begin
      if (n_bytes < {1'b0, PAYLOAD_START} || n_bytes != FRAME_OVERHEAD + {2'b00, pld_len_nxt})
        status = ST_LENGTH;
      else if (flags_nxt[FL_CSUM]) status = ST_CSUM;
      else if (flags_nxt[FL_HDR])  status = ST_HEADER;
      else if (flags_nxt[FL_ZERO]) status = ST_ZERO;
      else if (flags_nxt[FL_SEP])  status = ST_SEP;
      else if (b != FOOTER_BYTE)   status = ST_FOOTER;
      else if (flags_nxt[FL_OVR])  status = ST_OVERRUN;

      res              = '0;
      res.out_kind     = KIND_STATUS;
      res.frame_status = status;
      res.msg_counter  = counter_nxt;
      res.message_type = mtype_nxt;
      res.message_len  = msg_len_nxt;
      res.payload_len  = pld_len_nxt;
      emit             = 1'b1;

      byte_cnt_nxt = '0;
      xor_nxt      = '0;
      flags_nxt    = '0;
      msg_len_nxt  = '0;
      counter_nxt  = '0;
      mtype_nxt    = '0;
      pld_len_nxt  = '0;
      phase_nxt    = PH_ID;
      cur_id_nxt   = '0;
      cur_len_nxt  = '0;
      vidx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      xor_r      <= '0;
      flags_r    <= '0;
      msg_len_r  <= '0;
      counter_r  <= '0;
      mtype_r    <= '0;
      pld_len_r  <= '0;
      phase_r    <= PH_ID;
      cur_id_r   <= '0;
      cur_len_r  <= '0;
      vidx_r     <= '0;
    end else if (acc) begin
      byte_cnt_r <= byte_cnt_nxt;
      xor_r      <= xor_nxt;
      flags_r    <= flags_nxt;
      msg_len_r  <= msg_len_nxt;
      counter_r  <= counter_nxt;
      mtype_r    <= mtype_nxt;
      pld_len_r  <= pld_len_nxt;
      phase_r    <= phase_nxt;
      cur_id_r   <= cur_id_nxt;
      cur_len_r  <= cur_len_nxt;
      vidx_r     <= vidx_nxt;
    end
  end

  // result register with skid entry; input stalls only when the skid is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc && emit;
      end
    end else if (out_valid_r) begin
      if (acc && emit) skid_valid_r <= 1'b1;
    end else begin
      out_valid_r <= acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_ch.ready) begin
      if (skid_valid_r) out_data_r <= skid_data_r;
      else if (acc && emit) out_data_r <= res;
    end else if (out_valid_r) begin
      if (acc && emit) skid_data_r <= res;
    end else if (acc && emit) begin
      out_data_r <= res;
    end
  end

  assign in_ch.ready         = !skid_valid_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_kind     = out_data_r.out_kind;
  assign out_ch.reg_id       = out_data_r.reg_id;
  assign out_ch.reg_len      = out_data_r.reg_len;
  assign out_ch.byte_pos     = out_data_r.byte_pos;
  assign out_ch.value_byte   = out_data_r.value_byte;
  assign out_ch.has_value    = out_data_r.has_value;
  assign out_ch.reg_done     = out_data_r.reg_done;
  assign out_ch.frame_status = out_data_r.frame_status;
  assign out_ch.msg_counter  = out_data_r.msg_counter;
  assign out_ch.message_type = out_data_r.message_type;
  assign out_ch.message_len  = out_data_r.message_len;
  assign out_ch.payload_len  = out_data_r.payload_len;

endmodule

// File: rtl/core/acfd_checker.sv
// port-level checks of the deframer and their attachment to the top level
module acfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_frame_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [2:0] out_frame_status
);

  // a stalled result keeps its kind and status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_frame_status))
    else $error("result changed while stalled");

  // a frame-end transfer into an empty output shows its status next cycle
  a_status_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_end && !out_valid |=> out_valid && out_kind)
    else $error("frame status missing after frame end");

  // input only stalls while a result is waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // output empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ac_link_frame_deframer_core acfd_checker u_acfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_frame_end     (in_ch.frame_end),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.out_kind),
  .out_frame_status (out_ch.frame_status)
);

// File: dv/acfd_check_pkg.sv
// scoreboard for the link frame deframer: byte-level prediction and result checks
`timescale 1ns / 1ps

package acfd_check_pkg;
  import acfd_pkg::*;

  class deframe_scoreboard;
    logic [8:0]        byte_count;
    logic [7:0]        xor_acc;
    logic [FL_W-1:0]   err_flags;
    logic [7:0]        cap_len;
    logic [7:0]        cap_counter;
    logic [15:0]       cap_type;
    logic [7:0]        cap_plen;
    logic [1:0]        walk_phase;
    logic [7:0]        rec_id;
    logic [7:0]        rec_len;
    logic [7:0]        val_idx;
    acfd_result_t      pending_results[$];
    int                errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count  = '0;
      xor_acc     = '0;
      err_flags   = '0;
      cap_len     = '0;
      cap_counter = '0;
      cap_type    = '0;
      cap_plen    = '0;
      walk_phase  = PH_ID;
      rec_id      = '0;
      rec_len     = '0;
      val_idx     = '0;
    endfunction

    function void queue_result(acfd_result_t r);
      pending_results = {pending_results, r};
    endfunction

    // advance the frame state by one accepted byte and queue what it should produce
    function void note_rx_byte(logic [7:0] b, logic fe);
      acfd_result_t r;
      int           pos;
      int           pay_end;
      int           n;
      bit           emit;
      logic [7:0]   r_pos;
      logic [7:0]   r_val;
      logic         r_has;
      logic         r_done;
      logic [2:0]   st;
      pos     = int'(byte_count);
      pay_end = int'(PAYLOAD_START) + int'(cap_plen);
      emit    = 1'b0;
      r_pos   = '0;
      r_val   = '0;
      r_has   = 1'b0;
      r_done  = 1'b0;
      if (pos < int'(PAYLOAD_START)) begin
        xor_acc ^= b;
        if ((pos == int'(POS_HDR0) && b != HDR_B0) || (pos == int'(POS_HDR1) && b != HDR_B1) ||
            (pos == int'(POS_HDR2) && b != HDR_B2)) err_flags[FL_HDR] = 1'b1;
        if (pos == int'(POS_LEN)) cap_len = b;
        if (pos >= int'(POS_ZERO_LO) && pos <= int'(POS_ZERO_HI) && b != 8'h00)
          err_flags[FL_ZERO] = 1'b1;
        if (pos == int'(POS_CNT)) cap_counter = b;
        if (pos == int'(POS_SEP) && b != SEP_BYTE) err_flags[FL_SEP] = 1'b1;
        if (pos == int'(POS_TYPE_HI)) cap_type[15:8] = b;
        if (pos == int'(POS_TYPE_LO)) cap_type[7:0] = b;
        if (pos == int'(POS_PLEN)) cap_plen = b;
      end else if (pos < pay_end) begin
        xor_acc ^= b;
        case (walk_phase)
          PH_ID: begin
            rec_id = b;
            // an id on the last payload byte has no room for its length
            if (pos + 1 >= pay_end) begin
              err_flags[FL_OVR] = 1'b1;
              walk_phase = PH_STOP;
            end else begin
              walk_phase = PH_LEN;
            end
          end
          PH_LEN: begin
            rec_len = b;
            if (pos + int'(b) >= pay_end) begin
              err_flags[FL_OVR] = 1'b1;
              walk_phase = PH_STOP;
            end else if (b == 8'h00) begin
              emit = 1'b1;
              r_done = 1'b1;
              walk_phase = PH_ID;
            end else begin
              val_idx = '0;
              walk_phase = PH_VAL;
            end
          end
          PH_VAL: begin
            emit  = 1'b1;
            r_pos = val_idx;
            r_val = b;
            r_has = 1'b1;
            if (int'(val_idx) + 1 >= int'(rec_len)) begin
              r_done = 1'b1;
              walk_phase = PH_ID;
            end else begin
              val_idx = val_idx + 8'd1;
            end
          end
          default: ;
        endcase
      end else if (pos == pay_end) begin
        if (b != xor_acc) err_flags[FL_CSUM] = 1'b1;
      end

      if (byte_count != BYTE_CNT_MAX) byte_count = byte_count + 9'd1;

      r = '0;
      r.msg_counter  = cap_counter;
      r.message_type = cap_type;
      r.message_len  = cap_len;
      r.payload_len  = cap_plen;
      if (fe) begin
        n = pos + 1;
        if (n < int'(PAYLOAD_START) || n != int'(FRAME_OVERHEAD) + int'(cap_plen)) st = ST_LENGTH;
        else if (err_flags[FL_CSUM]) st = ST_CSUM;
        else if (err_flags[FL_HDR]) st = ST_HEADER;
        else if (err_flags[FL_ZERO]) st = ST_ZERO;
        else if (err_flags[FL_SEP]) st = ST_SEP;
        else if (b != FOOTER_BYTE) st = ST_FOOTER;
        else if (err_flags[FL_OVR]) st = ST_OVERRUN;
        else st = ST_OK;
        r.out_kind     = KIND_STATUS;
        r.frame_status = st;
        queue_result(r);
        clear_frame();
      end else if (emit) begin
        r.out_kind   = KIND_REG;
        r.reg_id     = rec_id;
        r.reg_len    = rec_len;
        r.byte_pos   = r_pos;
        r.value_byte = r_val;
        r.has_value  = r_has;
        r.reg_done   = r_done;
        queue_result(r);
      end
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(acfd_result_t got);
      acfd_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      cmp_field("out_kind", want.out_kind, got.out_kind);
      cmp_field("reg_id", want.reg_id, got.reg_id);
      cmp_field("reg_len", want.reg_len, got.reg_len);
      cmp_field("byte_pos", want.byte_pos, got.byte_pos);
      cmp_field("value_byte", want.value_byte, got.value_byte);
      cmp_field("has_value", want.has_value, got.has_value);
      cmp_field("reg_done", want.reg_done, got.reg_done);
      cmp_field("frame_status", want.frame_status, got.frame_status);
      cmp_field("msg_counter", want.msg_counter, got.msg_counter);
      cmp_field("message_type", want.message_type, got.message_type);
      cmp_field("message_len", want.message_len, got.message_len);
      cmp_field("payload_len", want.payload_len, got.payload_len);
    endfunction
  endclass

endpackage

// File: dv/ac_link_frame_deframer_core_test.sv
// top-level testbench of the link frame deframer core
`timescale 1ns / 1ps

module ac_link_frame_deframer_core_test;
  import acfd_pkg::*;
  import acfd_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BYTES    = 50;

  typedef enum int {
    FAULT_NONE, FAULT_HDR, FAULT_ZERO, FAULT_SEP, FAULT_CSUM, FAULT_FOOTER,
    FAULT_SHORT, FAULT_LONG, FAULT_OVERRUN, FAULT_LONE_ID, FAULT_MIXED, FAULT_NOISE
  } fault_e;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   idle_cycles = 0;

  acfd_in_if  in_ch ();
  acfd_out_if out_ch ();

  ac_link_frame_deframer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframe_scoreboard board;
  acfd_result_t      seen;

  // same field order as the packed result struct
  assign seen = {out_ch.out_kind, out_ch.reg_id, out_ch.reg_len, out_ch.byte_pos,
                 out_ch.value_byte, out_ch.has_value, out_ch.reg_done, out_ch.frame_status,
                 out_ch.msg_counter, out_ch.message_type, out_ch.message_len,
                 out_ch.payload_len};

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(seen);
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] v);
    q = {q, v};
  endfunction

  task automatic send_byte(logic [7:0] b, logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.frame_end <= fe;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_rx_byte(b, fe);
  endtask

  task automatic send_frame(logic [7:0] fr[$]);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  // hold the sender off until every pending result has been seen
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void random_payload(ref logic [7:0] pay[$], input int cap);
    int n;
    int len;
    pay.delete();
    n = $urandom_range(0, 4);
    repeat (n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
      if (pay.size() + 2 + len > cap) break;
      append_byte(pay, 8'($urandom));
      append_byte(pay, 8'(len));
      repeat (len) append_byte(pay, 8'($urandom));
    end
  endfunction

  function automatic void build_frame(ref logic [7:0] fr[$], input logic [7:0] pay[$],
                                      input fault_e fault);
    logic [7:0] csum;
    logic [7:0] footer;
    logic [7:0] nz;
    int         cut;
    nz = 8'($urandom_range(1, 255));
    fr.delete();
    append_byte(fr, HDR_B0);
    append_byte(fr, HDR_B1);
    append_byte(fr, HDR_B2);
    append_byte(fr, 8'($urandom));
    repeat (5) append_byte(fr, 8'h00);
    append_byte(fr, 8'($urandom));
    append_byte(fr, SEP_BYTE);
    append_byte(fr, 8'($urandom));
    append_byte(fr, 8'($urandom));
    append_byte(fr, 8'(pay.size()));
    foreach (pay[i]) append_byte(fr, pay[i]);
    case (fault)
      FAULT_HDR:   fr[$urandom_range(0, 2)] ^= nz;
      FAULT_ZERO:  fr[$urandom_range(4, 8)] ^= nz;
      FAULT_SEP:   fr[10] ^= nz;
      FAULT_MIXED: begin
        fr[$urandom_range(0, 2)] ^= nz;
        fr[$urandom_range(4, 10)] ^= nz;
      end
      default: ;
    endcase
    // checksum covers every byte before it, faults included
    csum = 8'h00;
    foreach (fr[i]) csum ^= fr[i];
    footer = FOOTER_BYTE;
    if (fault == FAULT_CSUM || fault == FAULT_MIXED) csum ^= nz;
    if (fault == FAULT_FOOTER || fault == FAULT_MIXED) footer ^= nz;
    append_byte(fr, csum);
    append_byte(fr, footer);
    if (fault == FAULT_SHORT) begin
      cut = $urandom_range(1, fr.size() - 1);
      fr = fr[0:cut-1];
    end
    if (fault == FAULT_LONG) repeat ($urandom_range(1, 4)) append_byte(fr, 8'($urandom));
  endfunction

  initial begin
    logic [7:0] fr[$];
    logic [7:0] pay[$];
    int         phase_bytes;
    int         ovr_len;
    fault_e     fault;

    board = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.rx_byte   <= 8'h00;
    in_ch.frame_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clean frame: empty register, then a two-byte register with extreme values
    pay = {8'h00, 8'h00, 8'hff, 8'h02, 8'h00, 8'hff};
    build_frame(fr, pay, FAULT_NONE);
    send_frame(fr);
    // frame end on the very first byte
    send_byte(8'hff, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph == 0) begin
        // full payload: one register of 253 bytes
        pay.delete();
        append_byte(pay, 8'($urandom));
        append_byte(pay, 8'd253);
        repeat (253) append_byte(pay, 8'($urandom));
        build_frame(fr, pay, FAULT_NONE);
        // trailing noise past the footer runs the byte counter into saturation
        repeat (250) append_byte(fr, 8'($urandom));
        send_frame(fr);
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if ($urandom_range(99) < 50) fault = FAULT_NONE;
        else fault = fault_e'($urandom_range(int'(FAULT_HDR), int'(FAULT_NOISE)));
        random_payload(pay, 240);
        if (fault == FAULT_OVERRUN) begin
          ovr_len = $urandom_range(1, 255);
          append_byte(pay, 8'($urandom));
          append_byte(pay, 8'(ovr_len));
          repeat ($urandom_range(0, (ovr_len - 1 < 6) ? ovr_len - 1 : 6))
            append_byte(pay, 8'($urandom));
        end
        if (fault == FAULT_LONE_ID) append_byte(pay, 8'($urandom));
        if (fault == FAULT_NOISE) begin
          fr.delete();
          repeat ($urandom_range(1, 30)) append_byte(fr, 8'($urandom));
        end else begin
          build_frame(fr, pay, fault);
        end
        send_frame(fr);
        phase_bytes += fr.size();
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
